[rtl/gda_pkg.sv]
// gda_pkg: shared types, mode codes and calendar helpers for the
// gregorian date arithmetic unit. No dependencies.
package gda_pkg;

  localparam int ACC_W = 19;

  typedef logic [11:0] year_t;
  typedef logic [3:0] month_t;
  typedef logic [4:0] day_t;
  typedef logic [8:0] ydays_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    year_t year;
    month_t month;
    day_t day;
  } date_t;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_DIFF = 2'd1,
    MODE_CMP  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  localparam year_t YEAR_MIN = 12'd1900;
  localparam year_t YEAR_MAX = 12'd2030;
  localparam month_t MONTH_LAST = 4'd12;
  localparam date_t DATE_EPOCH = '{year: 12'd1900, month: 4'd1, day: 5'd1};

  // exact for years 1700 to 2300
  function automatic logic is_leap(year_t y);
    return (y[1:0] == 2'b00) &&
           !(y == 12'd1700 || y == 12'd1800 || y == 12'd1900 ||
             y == 12'd2100 || y == 12'd2200 || y == 12'd2300);
  endfunction

  function automatic ydays_t days_of_year(year_t y);
    return is_leap(y) ? 9'd366 : 9'd365;
  endfunction

  function automatic day_t month_days(year_t y, month_t m);
    day_t len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = is_leap(y) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[rtl/gregorian_date_arithmetic_unit.sv]
// gregorian_date_arithmetic_unit: top level, sequencer around one shared
// day-count adder. Depends on gda_pkg and gda_date_check.
//
// Usage: one input beat on s_axis carries two dates, a signed day offset and
// the mode in tuser. Both dates are validated; a bad date becomes 1900-01-01.
// Mode 0 shifts the first date by the offset, mode 1 gives the absolute day
// difference, mode 2 tells whether the first date is earlier, mode 3 gives
// zeros. One output beat on m_axis follows each input beat.
// Sequencing: the sequencer walks one year or one month per cycle through the
// shared adder. Compare and unused modes skip the walk and go straight to
// the output. Difference walks both dates to day counts from 1900-01-01
// and takes their absolute difference. Add forms the day count of the
// first date plus the offset, then walks years away from 1900 and the
// months of the final year to turn the count back into a date.
// s_axis_tready is high only while idle; one item is in work at a time.
// The result sits in an output register: a stalled receiver holds it, and
// the next item may be accepted meanwhile, but it completes only once the
// register is free. Reset empties the sequencer and the output register.
module gregorian_date_arithmetic_unit
  import gda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year, month, day, other_year, other_month, other_day, day_offset, pad
  input  logic [63:0] s_axis_tdata,
  // mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_year, out_month, out_day, day_difference, is_earlier, pad
  output logic [39:0] m_axis_tdata,
  // first_was_valid
  output logic [0:0]  m_axis_tuser
);

  typedef enum logic [3:0] {
    S_IDLE, S_YEAR, S_MONTH, S_DAY, S_OFFSET, S_DIFF, S_ABS,
    S_BACK, S_FWD, S_MDIV, S_DONE
  } state_t;

  state_t state;
  mode_t mode;
  date_t d1, d2, raw1, raw2, fix1, fix2, wdate;
  logic ok1, ok2_unused, ok1_in, sel2;
  logic signed [16:0] offset;
  acc_t acc, c1, operand, sum;
  year_t yy, md_year;
  month_t mm;
  ydays_t yd_cur, yd_prev;
  day_t md;

  year_t out_year;
  month_t out_month;
  day_t out_day;
  logic [15:0] day_difference;
  logic is_earlier, first_was_valid;

  assign raw1 = '{year: s_axis_tdata[11:0], month: s_axis_tdata[15:12],
                  day: s_axis_tdata[20:16]};
  assign raw2 = '{year: s_axis_tdata[32:21], month: s_axis_tdata[36:33],
                  day: s_axis_tdata[41:37]};

  gda_date_check u_check1 (.raw(raw1), .fixed(fix1), .ok(ok1_in));
  gda_date_check u_check2 (.raw(raw2), .fixed(fix2), .ok(ok2_unused));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata = {2'b00, is_earlier, day_difference, out_day, out_month, out_year};
  assign m_axis_tuser = first_was_valid;

  assign wdate = sel2 ? d2 : d1;
  assign md_year = (state == S_MDIV) ? yy : wdate.year;
  assign yd_cur = days_of_year(yy);
  assign yd_prev = days_of_year(yy - 12'd1);
  assign md = month_days(md_year, mm);

  // shared day-count adder
  always_comb begin
    unique case (state)
      S_YEAR:   operand = $signed({{(ACC_W-9){1'b0}}, yd_cur});
      S_MONTH:  operand = $signed({{(ACC_W-5){1'b0}}, md});
      S_DAY:    operand = $signed({{(ACC_W-5){1'b0}}, wdate.day}) - acc_t'(1);
      S_OFFSET: operand = {{(ACC_W-17){offset[16]}}, offset};
      S_DIFF:   operand = -c1;
      S_BACK:   operand = $signed({{(ACC_W-9){1'b0}}, yd_prev});
      S_FWD:    operand = -$signed({{(ACC_W-9){1'b0}}, yd_cur});
      S_MDIV:   operand = -$signed({{(ACC_W-5){1'b0}}, md});
      default:  operand = '0;
    endcase
    sum = acc + operand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      sel2 <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mode <= mode_t'(s_axis_tuser);
            d1 <= fix1;
            d2 <= fix2;
            ok1 <= ok1_in;
            offset <= s_axis_tdata[58:42];
            acc <= '0;
            yy <= YEAR_MIN;
            mm <= 4'd1;
            sel2 <= 1'b0;
            if (s_axis_tuser == MODE_ADD || s_axis_tuser == MODE_DIFF) begin
              state <= S_YEAR;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_YEAR: begin
          if (yy < wdate.year) begin
            acc <= sum;
            yy <= yy + 12'd1;
          end else begin
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (mm < wdate.month) begin
            acc <= sum;
            mm <= mm + 4'd1;
          end else begin
            state <= S_DAY;
          end
        end
        S_DAY: begin
          if (mode == MODE_ADD) begin
            acc <= sum;
            state <= S_OFFSET;
          end else if (!sel2) begin
            c1 <= sum;
            acc <= '0;
            yy <= YEAR_MIN;
            mm <= 4'd1;
            sel2 <= 1'b1;
            state <= S_YEAR;
          end else begin
            acc <= sum;
            state <= S_DIFF;
          end
        end
        S_OFFSET: begin
          acc <= sum;
          yy <= YEAR_MIN;
          mm <= 4'd1;
          state <= S_BACK;
        end
        S_DIFF: begin
          acc <= sum;
          state <= S_ABS;
        end
        S_ABS: begin
          if (acc[ACC_W-1]) begin
            acc <= -acc;
          end
          state <= S_DONE;
        end
        S_BACK: begin
          if (acc[ACC_W-1]) begin
            acc <= sum;
            yy <= yy - 12'd1;
          end else begin
            state <= S_FWD;
          end
        end
        S_FWD: begin
          if (!sum[ACC_W-1]) begin
            acc <= sum;
            yy <= yy + 12'd1;
          end else begin
            state <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (mm < MONTH_LAST && !sum[ACC_W-1]) begin
            acc <= sum;
            mm <= mm + 4'd1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            first_was_valid <= ok1;
            out_year <= (mode == MODE_ADD) ? yy : 12'd0;
            out_month <= (mode == MODE_ADD) ? mm : 4'd0;
            out_day <= (mode == MODE_ADD) ? acc[4:0] + 5'd1 : 5'd0;
            day_difference <= (mode == MODE_DIFF) ? acc[15:0] : 16'd0;
            is_earlier <= (mode == MODE_CMP) && (d1 < d2);
            sel2 <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a beat is in work");

  a_year_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_YEAR |-> yy <= YEAR_MAX)
    else $error("year walk ran past the valid range");

  a_month_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MDIV |-> mm != 4'd0 && mm <= MONTH_LAST)
    else $error("month split out of range");

  a_abs_positive: assert property (@(posedge clk) disable iff (rst)
    state == S_ABS |=> !acc[ACC_W-1])
    else $error("difference still negative after abs");

  a_second_walk_mode: assert property (@(posedge clk) disable iff (rst)
    sel2 && state != S_IDLE |-> mode == MODE_DIFF)
    else $error("second date walked outside difference mode");

endmodule

[rtl/gda_date_check.sv]
// gda_date_check: range and month length check of one date, with
// substitution of the epoch date on failure. Depends on gda_pkg.
module gda_date_check
  import gda_pkg::*;
(
  input  date_t raw,
  output date_t fixed,
  output logic  ok
);

  day_t len;

  always_comb begin
    len = month_days(raw.year, raw.month);
    ok = (raw.year >= YEAR_MIN) && (raw.year <= YEAR_MAX) &&
         (raw.month != 4'd0) && (raw.month <= MONTH_LAST) &&
         (raw.day != 5'd0) && (raw.day <= len);
    fixed = ok ? raw : DATE_EPOCH;
  end

endmodule
